### rtl/dspd_pkg.sv
`timescale 1ns / 1ps

package dspd_pkg;

    // Fixed field and register widths
    localparam int TARGET_W   = 14;
    localparam int PERIOD_W   = 10;
    localparam int DUTY_W     = 7;
    localparam int INTEG_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // Register values after reset
    localparam logic [TARGET_W-1:0] TARGET_RESET = 14'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd100;
    localparam logic [DUTY_W-1:0]   MIN_RESET    = 7'd10;
    localparam logic [DUTY_W-1:0]   MAX_RESET    = 7'd95;

    // Integral clamp
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 11'sd1000;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = -11'sd1000;

    // Divide by 10 on |integral| <= 1000: (m * 205) >> 11 is exact below 1024
    localparam int              MAG10_W     = 10;
    localparam int              PROD10_W    = 18;
    localparam int              DIV10_SHIFT = 11;
    localparam int              Q10_W       = 7;
    localparam logic [7:0]      DIV10_MUL   = 8'd205;

    // Divide by 100 on a magnitude capped at 12800: (m * 5243) >> 19 is exact
    // below 43699; any quotient of 128 or more saturates the duty anyway
    localparam int                PID_MAG_W    = 14;
    localparam int                PROD100_W    = 27;
    localparam int                DIV100_SHIFT = 19;
    localparam int                Q100_W       = 8;
    localparam logic [12:0]       DIV100_MUL   = 13'd5243;
    localparam logic [PID_MAG_W-1:0] PID_MAG_SAT = 14'd12800;
    localparam logic [Q100_W-1:0] Q100_MAX     = 8'd128;

    // Working width of the duty sum
    localparam int DSUM_W = 10;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_SPEED  = 2'd0,
        CFG_UPDATE_PERIOD = 2'd1,
        CFG_MIN_DUTY      = 2'd2,
        CFG_MAX_DUTY      = 2'd3
    } cfg_idx_t;

    // Control bits that travel with the last pipeline stage
    typedef struct packed {
        logic valid;
        logic upd;
        logic neg;
    } dspd_step_t;

endpackage

### rtl/dspd_duty_acc.sv
`timescale 1ns / 1ps

module dspd_duty_acc
    import dspd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dspd_step_t           step,
    input  logic [PROD100_W-1:0] prod,
    input  logic [DUTY_W-1:0]    min_duty,
    input  logic [DUTY_W-1:0]    max_duty,
    input  logic                 out_ready,
    output logic                 take,
    output logic                 out_valid,
    output logic [DUTY_W-1:0]    duty_level,
    output logic                 updated
);

    logic                     out_valid_reg;
    logic [DUTY_W-1:0]        duty_store_reg;
    logic [DUTY_W-1:0]        duty_out_reg;
    logic                     updated_reg;
    logic [Q100_W-1:0]        step_mag;
    logic signed [DSUM_W-1:0] duty_sum;
    logic [DUTY_W-1:0]        duty_next;

    // Output register is free when empty or being drained
    assign take = !out_valid_reg || out_ready;

    // Finish the divide by 100 and apply the step with saturation
    always_comb
    begin
        step_mag = prod[PROD100_W-1:DIV100_SHIFT];
        if (step.neg)
        begin
            duty_sum = $signed(DSUM_W'(duty_store_reg)) - $signed(DSUM_W'(step_mag));
        end
        else
        begin
            duty_sum = $signed(DSUM_W'(duty_store_reg)) + $signed(DSUM_W'(step_mag));
        end
        duty_next = duty_sum[DUTY_W-1:0];
        if (duty_sum > $signed(DSUM_W'(max_duty)))
        begin
            duty_next = max_duty;
        end
        // min is applied last, so it wins over max
        if ((duty_sum < $signed(DSUM_W'(min_duty))) ||
            (duty_next < min_duty))
        begin
            duty_next = min_duty;
        end
    end

    // Hold the word valid flag and the stored duty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            duty_store_reg <= '0;
        end
        else if (take)
        begin
            out_valid_reg <= step.valid;
            if (step.valid && step.upd)
            begin
                duty_store_reg <= duty_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take && step.valid)
        begin
            duty_out_reg <= step.upd ? duty_next : duty_store_reg;
            updated_reg  <= step.upd;
        end
    end

    assign out_valid  = out_valid_reg;
    assign duty_level = duty_out_reg;
    assign updated    = updated_reg;

endmodule

### rtl/decimated_speed_pid_duty_unit.sv
`timescale 1ns / 1ps

// Channel | Signals                              | Word
// --------+--------------------------------------+-------------------------------
// in      | in_valid, in_ready                   | measured_speed
// out     | out_valid, out_ready                 | duty_level, updated
// cfg     | cfg_valid, cfg_ready, cfg_index      | cfg_data (always ready)
//
// Accepts one tick per cycle unless the output stalls; the result is registered
// in stages 0 to 3 and the output stage. The rate is set by the integral-clamp
// loop (stage 1) and the duty accumulate loop (output stage), each closed in its stage.
// Reset clears the tick count, integral, last error and duty to zero and
// loads the register defaults. Each stage holds when the one after it is
// full and stalled, so bubbles close up and input keeps flowing.

module decimated_speed_pid_duty_unit
    import dspd_pkg::*;
#(
    parameter int SPEED_WIDTH = 14
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SPEED_WIDTH-1:0] measured_speed,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [DUTY_W-1:0]      duty_level,
    output logic                   updated,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ERR_W = ((SPEED_WIDTH > TARGET_W) ? SPEED_WIDTH : TARGET_W) + 1;
    localparam int SUM_W = ERR_W + 1;
    localparam int DIF_W = ERR_W + 3;
    localparam int PID_W = DIF_W + 1;

    // Configuration registers
    logic [TARGET_W-1:0] target_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [DUTY_W-1:0]   min_duty_reg;
    logic [DUTY_W-1:0]   max_duty_reg;

    // Controller state
    logic [PERIOD_W-1:0]       tick_count_reg;
    logic signed [INTEG_W-1:0] error_sum_reg;
    logic signed [ERR_W-1:0]   prev_error_reg;

    // Pipeline registers
    logic                      v0_reg;
    logic [SPEED_WIDTH-1:0]    speed0_reg;
    logic                      v1_reg;
    logic                      upd1_reg;
    logic signed [ERR_W-1:0]   err1_reg;
    logic signed [ERR_W-1:0]   prev1_reg;
    logic signed [INTEG_W-1:0] integ1_reg;
    logic                      v2_reg;
    logic                      upd2_reg;
    logic                      neg2_reg;
    logic [PROD10_W-1:0]       prod10_reg;
    logic signed [DIF_W-1:0]   dif2_reg;
    dspd_step_t                step3_reg;
    logic [PROD100_W-1:0]      prod100_reg;

    // Stage enables
    logic free0;
    logic free1;
    logic free2;
    logic free3;
    logic out_take;

    // Stage 1 signals
    logic [PERIOD_W:0]         tick_next;
    logic                      do_upd;
    logic signed [ERR_W-1:0]   err;
    logic signed [SUM_W-1:0]   sum;
    logic signed [INTEG_W-1:0] integ;

    // Stage 2 signals
    logic [INTEG_W-1:0]        integ_neg;
    logic [MAG10_W-1:0]        mag10;
    logic signed [DIF_W-1:0]   err_x;
    logic signed [DIF_W-1:0]   prev_x;
    logic signed [DIF_W-1:0]   dif;

    // Stage 3 signals
    logic [Q10_W-1:0]          q10;
    logic signed [PID_W-1:0]   q10_x;
    logic signed [PID_W-1:0]   pid;
    logic [PID_W-1:0]          pid_abs;
    logic [PID_MAG_W-1:0]      pid_mag;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= TARGET_RESET;
            period_reg   <= PERIOD_RESET;
            min_duty_reg <= MIN_RESET;
            max_duty_reg <= MAX_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TARGET_SPEED:  target_reg   <= cfg_data[TARGET_W-1:0];
                CFG_UPDATE_PERIOD: period_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_MIN_DUTY:      min_duty_reg <= cfg_data[DUTY_W-1:0];
                CFG_MAX_DUTY:      max_duty_reg <= cfg_data[DUTY_W-1:0];
                default:           target_reg   <= target_reg;
            endcase
        end
    end

    // Backward enable chain
    assign free3    = !step3_reg.valid || out_take;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign free0    = !v0_reg || free1;
    assign in_ready = free0;

    // Stage 0: capture the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (free0)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free0 && in_valid)
        begin
            speed0_reg <= measured_speed;
        end
    end

    // Stage 1: tick decision, error and clamped integral
    always_comb
    begin
        tick_next = {1'b0, tick_count_reg} + (PERIOD_W + 1)'(1);
        do_upd    = tick_next >= {1'b0, period_reg};
        err       = $signed(ERR_W'(target_reg)) - $signed(ERR_W'(speed0_reg));
        sum       = SUM_W'(error_sum_reg) + SUM_W'(err);
        if (sum > SUM_W'(INTEG_MAX))
        begin
            integ = INTEG_MAX;
        end
        else if (sum < SUM_W'(INTEG_MIN))
        begin
            integ = INTEG_MIN;
        end
        else
        begin
            integ = sum[INTEG_W-1:0];
        end
    end

    // Advance controller state as each tick passes stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
            v1_reg         <= 1'b0;
        end
        else if (free1)
        begin
            v1_reg <= v0_reg;
            if (v0_reg)
            begin
                if (do_upd)
                begin
                    tick_count_reg <= '0;
                    error_sum_reg  <= integ;
                    prev_error_reg <= err;
                end
                else
                begin
                    tick_count_reg <= tick_next[PERIOD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free1)
        begin
            upd1_reg   <= do_upd;
            err1_reg   <= err;
            prev1_reg  <= prev_error_reg;
            integ1_reg <= integ;
        end
    end

    // Stage 2: integral / 10 by reciprocal, 3*err - last error
    always_comb
    begin
        integ_neg = -integ1_reg;
        mag10     = integ1_reg[INTEG_W-1] ? integ_neg[MAG10_W-1:0]
                                          : integ1_reg[MAG10_W-1:0];
        err_x     = DIF_W'(err1_reg);
        prev_x    = DIF_W'(prev1_reg);
        dif       = (err_x <<< 1) + err_x - prev_x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (free2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free2)
        begin
            upd2_reg   <= upd1_reg;
            neg2_reg   <= integ1_reg[INTEG_W-1];
            prod10_reg <= PROD10_W'(mag10) * PROD10_W'(DIV10_MUL);
            dif2_reg   <= dif;
        end
    end

    // Stage 3: controller output, magnitude capped, times 1/100 reciprocal
    always_comb
    begin
        q10     = prod10_reg[PROD10_W-1:DIV10_SHIFT];
        q10_x   = PID_W'($signed({1'b0, q10}));
        pid     = neg2_reg ? (PID_W'(dif2_reg) - q10_x) : (PID_W'(dif2_reg) + q10_x);
        pid_abs = pid[PID_W-1] ? PID_W'(-pid) : PID_W'(pid);
        if (pid_abs > PID_W'(PID_MAG_SAT))
        begin
            pid_mag = PID_MAG_SAT;
        end
        else
        begin
            pid_mag = pid_abs[PID_MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step3_reg   <= '0;
            prod100_reg <= '0;
        end
        else if (free3)
        begin
            step3_reg.valid <= v2_reg;
            step3_reg.upd   <= upd2_reg;
            step3_reg.neg   <= pid[PID_W-1];
            prod100_reg     <= PROD100_W'(pid_mag) * PROD100_W'(DIV100_MUL);
        end
    end

    // Output stage: duty accumulate and result register
    dspd_duty_acc u_duty
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step3_reg),
        .prod       (prod100_reg),
        .min_duty   (min_duty_reg),
        .max_duty   (max_duty_reg),
        .out_ready  (out_ready),
        .take       (out_take),
        .out_valid  (out_valid),
        .duty_level (duty_level),
        .updated    (updated)
    );

    // Integral never leaves its clamp range
    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        (error_sum_reg >= INTEG_MIN) && (error_sum_reg <= INTEG_MAX))
        else $error("error sum outside clamp range");

    // Tick count stays below the largest period
    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_count_reg != {PERIOD_W{1'b1}})
        else $error("tick count reached the all-ones value");

    // Capped magnitude keeps the duty step within 128
    a_step_cap: assert property (@(posedge clk) disable iff (!rst_n)
        step3_reg.valid |-> (prod100_reg[PROD100_W-1:DIV100_SHIFT] <= Q100_MAX))
        else $error("duty step above cap");

    // A full pipeline behind a stalled output refuses input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v0_reg && v1_reg && v2_reg && step3_reg.valid && out_valid && !out_ready)
        |-> !in_ready)
        else $error("input taken while pipeline full and stalled");

endmodule
